// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the compensation design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// response a fixed number of cycles after the trigger
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed: delayed response");

`endif

// ===== design/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg
// types, constants and helpers for the temperature / humidity compensation
// ----------------------------------------------------------------------------
package thc_pkg;

  // fixed temperature calibration
  localparam int TEMP_CAL_ONE   = 26487;
  localparam int TEMP_CAL_TWO   = 26223;
  localparam int TEMP_CAL_THREE = 3;
  localparam int TEMP_B_MUL     = TEMP_CAL_THREE * 16;
  localparam int ROUND_HALF     = 128;

  localparam int HUM_MAX_MILLI  = 100000;
  localparam int MILLI_PER_UNIT = 1000;
  localparam int HUM_GAIN_BASE  = 16384;

  // reciprocal constants: exact for dividends below 2^23 and 2^17
  localparam logic [23:0] DIV100_MUL  = 24'd10737419;  // ceil(2^30 / 100)
  localparam logic [17:0] DIV1000_MUL = 18'd134218;    // ceil(2^27 / 1000)

  localparam int PIPE_DEPTH = 19;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_CAL_ONE   = 3'd0,
    REG_HUM_CAL_TWO   = 3'd1,
    REG_HUM_CAL_THREE = 3'd2,
    REG_HUM_CAL_FOUR  = 3'd3,
    REG_HUM_CAL_FIVE  = 3'd4,
    REG_HUM_CAL_SIX   = 3'd5,
    REG_HUM_CAL_SEVEN = 3'd6
  } thc_reg_e;

  typedef struct packed {
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } thc_in_t;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic signed [7:0]  temp_whole;
    logic [16:0]        hum_milli;
    logic [6:0]         hum_whole;
  } thc_out_t;

  // magnitude of x / 100, truncated; |x| must stay below 2^23
  function automatic logic [16:0] div100_abs(input logic signed [24:0] x);
    logic [24:0] mag;
    logic [46:0] prod;
    mag  = x[24] ? 25'(-x) : 25'(x);
    prod = 47'(mag[22:0]) * 47'(DIV100_MUL);
    return prod[46:30];
  endfunction

  // x / 1000 for x in 0..100000
  function automatic logic [6:0] div1000(input logic [16:0] x);
    logic [34:0] prod;
    prod = 35'(x) * 35'(DIV1000_MUL);
    return prod[33:27];
  endfunction

endpackage

// ===== design/temp_humidity_compensation.sv =====
// ----------------------------------------------------------------------------
// temp_humidity_compensation
// integer temperature and humidity compensation, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   item channel: raise start with item_i (raw temperature and humidity);
//   the item is taken at an edge where start is high and busy is low. busy
//   stays low, so a new item can be taken at every edge.
//   result channel: done_o is high for one cycle with result_o; the receiver
//   cannot hold results off, so none is ever stalled or dropped.
//   config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i write the seven humidity calibration words (ready is always
//   high); write them only while no item is in flight.
// timing:
//   throughput is one item per cycle; the depth is set by the chain of
//   multiply and reciprocal-divide stages.
// reset:
//   rst_ni clears the calibration words to zero and empties the pipeline;
//   items in flight are lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module temp_humidity_compensation import thc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  thc_in_t               item_i,
  output logic                  done_o,
  output thc_out_t              result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // calibration words
  logic [11:0] h1_q, h2_q;
  logic [7:0]  h3_q, h4_q, h5_q, h6_q, h7_q;

  logic                  accept;
  logic [PIPE_DEPTH:1]   vld_q;

  // stage 1: offset the raw temperature
  logic signed [17:0] d1_d, d1_q;
  logic signed [16:0] b1_d, b1_q;
  // stage 2: linear and square terms
  logic signed [31:0] pa2_d, pa2_q;
  logic signed [33:0] bsq2;
  logic [30:0]        pb2_d, pb2_q;
  // stage 3
  logic signed [20:0] a3_d, a3_q;
  logic [24:0]        c3_d, c3_q;
  // stage 4: fine temperature
  logic signed [21:0] fine4_d, fine4_q;
  // stage 5: hundredths of a degree
  logic signed [23:0] f5, r5;
  logic signed [15:0] t5_d;
  // stage 6: temperature products
  logic signed [23:0] p3_d, p3_q, p4_d, p4_q, p5_d, p5_q, p7_d, p7_q;
  logic [7:0]         tq6_d, tq6_q;
  logic               ts6_q;
  // stage 7: divide by 100 (magnitudes)
  logic [14:0]        m3_d, m3_q, m4_d, m4_q, m5_d, m5_q, m7_d, m7_q;
  logic               s3_q, s4_q, s5_q, s7_q;
  logic [7:0]         twl;
  logic signed [7:0]  tw7_d;
  // stage 8: signed quotients
  logic signed [15:0] q3_d, q3_q, q4_d, q4_q, q5_d, q5_q, q7_d, q7_q;
  // stage 9: offset, second order coefficient, gain start
  logic signed [30:0] p55_d, p55_q;
  logic signed [17:0] off9_d;
  logic signed [16:0] secs;
  logic signed [12:0] sec9_d;
  logic signed [16:0] g9_d;
  // stage 10
  logic [16:0]        m55_d, m55_q;
  logic               s55_q;
  // stage 11
  logic signed [17:0] gx, mx, gain11_d, gain11_q;
  // stage 12
  logic signed [29:0] gh12_d, gh12_q;
  // stage 13
  logic signed [37:0] pf13;
  logic signed [31:0] prod13_d;
  // stage 14
  logic signed [35:0] sqf;
  logic [31:0]        sqsq14_d, sqsq14_q;
  // stage 15
  logic signed [34:0] cf;
  logic [31:0]        corp15_d, corp15_q;
  // stage 16
  logic signed [31:0] s16_d, s16_q;
  // stage 17
  logic signed [32:0] vf;
  logic [31:0]        v17_d, v17_q;
  // stage 18: clamp
  logic signed [19:0] hs;
  logic [16:0]        hum18_d, hum18_q;
  // stage 19: result register
  thc_out_t           res_d, res_q;

  // delay lines for values used further down
  logic signed [15:0] t_q    [5:18];
  logic signed [7:0]  tw_q   [7:18];
  logic [15:0]        hraw_q [1:8];
  logic signed [17:0] off_q  [9:12];
  logic signed [12:0] sec_q  [9:14];
  logic signed [16:0] g_q    [9:10];
  logic signed [31:0] prod_q [13:15];

  // the pipeline never stalls, so the item side is always open
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= '0;
      h2_q <= '0;
      h3_q <= '0;
      h4_q <= '0;
      h5_q <= '0;
      h6_q <= '0;
      h7_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HUM_CAL_ONE:   h1_q <= cfg_data_i[11:0];
        REG_HUM_CAL_TWO:   h2_q <= cfg_data_i[11:0];
        REG_HUM_CAL_THREE: h3_q <= cfg_data_i[7:0];
        REG_HUM_CAL_FOUR:  h4_q <= cfg_data_i[7:0];
        REG_HUM_CAL_FIVE:  h5_q <= cfg_data_i[7:0];
        REG_HUM_CAL_SIX:   h6_q <= cfg_data_i[7:0];
        REG_HUM_CAL_SEVEN: h7_q <= cfg_data_i[7:0];
        default: ;  // index beyond the register list: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // valid bits, one per stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-1:1], accept};
    end
  end

  // --------------------------------------------------------------------------
  // datapath, next values per stage
  // all intermediates follow 32-bit wrapping arithmetic; widths below are
  // the ranges the values can actually reach, except where a 32-bit wrap
  // happens (prod, square, correction, scaled humidity)
  // --------------------------------------------------------------------------
  always_comb begin
    // stage 1: d = 2*raw - 2*c1, b = d >> 1 = raw - c1
    d1_d = $signed({1'b0, item_i.temp_raw, 1'b0}) - $signed(18'(2 * TEMP_CAL_ONE));
    b1_d = $signed({1'b0, item_i.temp_raw}) - $signed(17'(TEMP_CAL_ONE));

    // stage 2: both products stay inside 32 bits
    pa2_d = d1_q * $signed(16'(TEMP_CAL_TWO));
    bsq2  = b1_q * b1_q;
    pb2_d = bsq2[30:0];

    // stage 3
    a3_d = pa2_q[31:11];
    c3_d = 25'(pb2_q[30:12]) * 25'(TEMP_B_MUL);

    // stage 4
    fine4_d = $signed({a3_q[20], a3_q}) + $signed({11'b0, c3_q[24:14]});

    // stage 5: (fine * 5 + 128) >>> 8
    f5   = {{2{fine4_q[21]}}, fine4_q};
    r5   = (f5 <<< 2) + f5 + $signed(24'(ROUND_HALF));
    t5_d = r5[23:8];

    // stage 6: temperature times the signed coefficients
    p3_d  = t_q[5] * $signed(h3_q);
    p4_d  = t_q[5] * $signed(h4_q);
    p5_d  = t_q[5] * $signed(h5_q);
    p7_d  = t_q[5] * $signed(h7_q);
    tq6_d = 8'(div100_abs({{9{t_q[5][15]}}, t_q[5]}));

    // stage 7: truncating divide by 100 on magnitudes
    m3_d  = 15'(div100_abs({p3_q[23], p3_q}));
    m4_d  = 15'(div100_abs({p4_q[23], p4_q}));
    m5_d  = 15'(div100_abs({p5_q[23], p5_q}));
    m7_d  = 15'(div100_abs({p7_q[23], p7_q}));
    twl   = tq6_q;
    tw7_d = ts6_q ? -$signed(twl) : $signed(twl);

    // stage 8: restore signs
    q3_d = s3_q ? -$signed({1'b0, m3_q}) : $signed({1'b0, m3_q});
    q4_d = s4_q ? -$signed({1'b0, m4_q}) : $signed({1'b0, m4_q});
    q5_d = s5_q ? -$signed({1'b0, m5_q}) : $signed({1'b0, m5_q});
    q7_d = s7_q ? -$signed({1'b0, m7_q}) : $signed({1'b0, m7_q});

    // stage 9
    p55_d  = t_q[8] * q5_q;
    off9_d = $signed({2'b0, hraw_q[8]}) - $signed({2'b0, h1_q, 4'b0})
           - $signed({{3{q3_q[15]}}, q3_q[15:1]});
    secs   = $signed({2'b0, h6_q, 7'b0}) + $signed({q7_q[15], q7_q});
    sec9_d = secs[16:4];
    g9_d   = $signed({q4_q[15], q4_q}) + $signed(17'(HUM_GAIN_BASE));

    // stage 10: quadratic gain term, (t * q5) >>> 6 then / 100
    m55_d = div100_abs($signed(p55_q[30:6]));

    // stage 11: gain before the h2 scale
    gx       = {g_q[10][16], g_q[10]};
    mx       = $signed({1'b0, m55_q});
    gain11_d = s55_q ? gx - mx : gx + mx;

    // stage 12
    gh12_d = $signed({1'b0, h2_q}) * gain11_q;

    // stage 13: offset times gain, wraps at 32 bits
    pf13     = off_q[12] * $signed(gh12_q[29:10]);
    prod13_d = pf13[31:0];

    // stage 14: square of prod >>> 14, wraps at 32 bits
    sqf      = $signed(prod_q[13][31:14]) * $signed(prod_q[13][31:14]);
    sqsq14_d = sqf[31:0];

    // stage 15: second order correction before its halving
    cf       = sec_q[14] * $signed(sqsq14_q[31:10]);
    corp15_d = cf[31:0];

    // stage 16
    s16_d = prod_q[15] + $signed({corp15_q[31], corp15_q[31:1]});

    // stage 17: to milli-percent
    vf    = $signed(s16_q[31:10]) * $signed(11'(MILLI_PER_UNIT));
    v17_d = vf[31:0];

    // stage 18: clamp to 0..100000
    hs = $signed(v17_q[31:12]);
    priority if (hs < 0) begin
      hum18_d = '0;
    end else if (hs > $signed(20'(HUM_MAX_MILLI))) begin
      hum18_d = 17'(HUM_MAX_MILLI);
    end else begin
      hum18_d = hs[16:0];
    end

    // stage 19: result
    res_d.temp_centi = t_q[18];
    res_d.temp_whole = tw_q[18];
    res_d.hum_milli  = hum18_q;
    res_d.hum_whole  = div1000(hum18_q);
  end

  // payload registers advance every cycle; valid bits mark live items
  always_ff @(posedge clk_i) begin
    d1_q     <= d1_d;
    b1_q     <= b1_d;
    pa2_q    <= pa2_d;
    pb2_q    <= pb2_d;
    a3_q     <= a3_d;
    c3_q     <= c3_d;
    fine4_q  <= fine4_d;
    p3_q     <= p3_d;
    p4_q     <= p4_d;
    p5_q     <= p5_d;
    p7_q     <= p7_d;
    tq6_q    <= tq6_d;
    ts6_q    <= t_q[5][15];
    m3_q     <= m3_d;
    m4_q     <= m4_d;
    m5_q     <= m5_d;
    m7_q     <= m7_d;
    s3_q     <= p3_q[23];
    s4_q     <= p4_q[23];
    s5_q     <= p5_q[23];
    s7_q     <= p7_q[23];
    q3_q     <= q3_d;
    q4_q     <= q4_d;
    q5_q     <= q5_d;
    q7_q     <= q7_d;
    p55_q    <= p55_d;
    m55_q    <= m55_d;
    s55_q    <= p55_q[30];
    gain11_q <= gain11_d;
    gh12_q   <= gh12_d;
    sqsq14_q <= sqsq14_d;
    corp15_q <= corp15_d;
    s16_q    <= s16_d;
    v17_q    <= v17_d;
    hum18_q  <= hum18_d;
    res_q    <= res_d;

    hraw_q[1] <= item_i.hum_raw;
    for (int i = 2; i <= 8; i++) begin
      hraw_q[i] <= hraw_q[i-1];
    end
    t_q[5] <= t5_d;
    for (int i = 6; i <= 18; i++) begin
      t_q[i] <= t_q[i-1];
    end
    tw_q[7] <= tw7_d;
    for (int i = 8; i <= 18; i++) begin
      tw_q[i] <= tw_q[i-1];
    end
    off_q[9] <= off9_d;
    for (int i = 10; i <= 12; i++) begin
      off_q[i] <= off_q[i-1];
    end
    sec_q[9] <= sec9_d;
    for (int i = 10; i <= 14; i++) begin
      sec_q[i] <= sec_q[i-1];
    end
    g_q[9]  <= g9_d;
    g_q[10] <= g_q[9];
    prod_q[13] <= prod13_d;
    prod_q[14] <= prod_q[13];
    prod_q[15] <= prod_q[14];
  end

  assign done_o   = vld_q[PIPE_DEPTH];
  assign result_o = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_DELAY(a_item_gives_result, clk_i, rst_ni, accept, PIPE_DEPTH, done_o)
  `ASSERT_IMPL(a_result_from_item, clk_i, rst_ni, done_o, $past(accept, PIPE_DEPTH))
  `ASSERT_IMPL(a_hum_clamped, clk_i, rst_ni, done_o, result_o.hum_milli <= 17'(HUM_MAX_MILLI))
  `ASSERT_IMPL(a_hum_whole_match, clk_i, rst_ni, done_o, (32'(result_o.hum_whole) * 32'(MILLI_PER_UNIT) <= 32'(result_o.hum_milli)) && (32'(result_o.hum_milli) < (32'(result_o.hum_whole) + 32'd1) * 32'(MILLI_PER_UNIT)))

endmodule
